// ===== hdl/stt_pkg.sv =====
// Package for the software timer table: sizes, operation, result and status codes,
// and the structs that pass between the sequencer and the entry table.
// Depends on nothing.
package stt_pkg;

    // Table size and derived index width
    localparam int NUM_TIMERS    = 16;
    localparam int QUEUE_ID_BITS = 4;
    localparam int IDX_BITS      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    // Operation codes
    localparam logic [2:0] OP_ALLOC = 3'd0;
    localparam logic [2:0] OP_FREE  = 3'd1;
    localparam logic [2:0] OP_BIND  = 3'd2;
    localparam logic [2:0] OP_ARM   = 3'd3;
    localparam logic [2:0] OP_TICK  = 3'd4;

    // Result kinds
    localparam logic [1:0] KIND_ACK    = 2'd0;
    localparam logic [1:0] KIND_EXPIRY = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;

    // Entry status codes
    localparam logic [1:0] ST_FREE  = 2'd0;
    localparam logic [1:0] ST_ALLOC = 2'd1;   // allocated flag
    localparam logic [1:0] ST_RUN   = 2'd2;   // running flag

    // Write command into the entry table
    typedef struct packed {
        logic                     status_we;
        logic [1:0]               status_val;
        logic                     bind_we;
        logic                     arm_we;
        logic [IDX_BITS-1:0]      addr;
        logic [31:0]              deadline;
        logic [QUEUE_ID_BITS-1:0] queue;
        logic [7:0]               payload;
    } tbl_wr_t;

    // Contents of one entry as read back
    typedef struct packed {
        logic [1:0]               status;
        logic [31:0]              deadline;
        logic [QUEUE_ID_BITS-1:0] queue;
        logic [7:0]               payload;
    } tbl_rd_t;

endpackage

// ===== hdl/stt_table.sv =====
// Entry storage of the software timer table: status, deadline, queue and data byte.
// One write port and one read port at the scan address. Uses stt_pkg.
module stt_table import stt_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  tbl_wr_t             wr,
    input  logic [IDX_BITS-1:0] rd_addr,
    output tbl_rd_t             rd
);

    logic [1:0]               status_reg   [NUM_TIMERS];
    logic [31:0]              deadline_reg [NUM_TIMERS];
    logic [QUEUE_ID_BITS-1:0] queue_reg    [NUM_TIMERS];
    logic [7:0]               payload_reg  [NUM_TIMERS];

    // Status: cleared to free at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
                status_reg[i] <= ST_FREE;
            end
        end else if (wr.status_we) begin
            status_reg[wr.addr] <= wr.status_val;
        end
    end

    // Deadline, queue and byte: hold whatever was written last
    always_ff @(posedge aclk) begin
        if (wr.arm_we) begin
            deadline_reg[wr.addr] <= wr.deadline;
        end
        if (wr.bind_we) begin
            queue_reg[wr.addr]   <= wr.queue;
            payload_reg[wr.addr] <= wr.payload;
        end
    end

    // Read the entry under the scan pointer
    assign rd.status   = status_reg[rd_addr];
    assign rd.deadline = deadline_reg[rd_addr];
    assign rd.queue    = queue_reg[rd_addr];
    assign rd.payload  = payload_reg[rd_addr];

endmodule

// ===== hdl/software_timer_table.sv =====
// Software timer table: input handshake, sequencer, tick counter and output register.
// Uses stt_pkg and stt_table.
//
// Usage: each input item carries one operation (allocate, free, bind, arm, tick)
// on s_* with s_valid/s_ready. Results leave on m_* with m_valid/m_ready; m_last
// marks the final result of an item. Allocate, free, bind, arm and unknown codes
// give one acknowledge; tick gives one expiry result per timer that fires, in
// index order, then a done result.
// Timing: free, bind and arm pass from idle to S_ACK, which loads the acknowledge
// into the output register once it is free. Allocate walks the status entries one
// per cycle through the sequencer. Tick walks every entry one per cycle through the
// single deadline comparator while the receiver keeps m_ready high. s_ready is high
// only while the sequencer is idle; the next item may be accepted while the final
// result still waits in the output register.
// Stalls: when m_ready is low with a result pending, a tick scan holds on the
// next firing entry until the output register frees up; nothing is lost.
// Reset: all entries become free, the tick count goes to zero and no result is
// pending. Deadline, queue and byte of an entry are undefined until written.
module software_timer_table import stt_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [2:0]               s_operation,
    input  logic [3:0]               s_timer_index,
    input  logic [31:0]              s_deadline,
    input  logic [QUEUE_ID_BITS-1:0] s_queue_id,
    input  logic [7:0]               s_payload_byte,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [1:0]               m_kind,
    output logic                     m_ok,
    output logic [3:0]               m_entry_index,
    output logic [QUEUE_ID_BITS-1:0] m_target_queue,
    output logic [7:0]               m_expiry_byte,
    output logic                     m_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACK,
        S_ALLOC,
        S_TICK,
        S_DONE
    } state_t;

    state_t                   state_reg;
    logic [IDX_BITS-1:0]      scan_idx_reg;
    logic [31:0]              tick_count_reg;
    logic                     ack_ok_reg;
    logic [3:0]               ack_idx_reg;

    logic                     m_valid_reg;
    logic [1:0]               m_kind_reg;
    logic                     m_ok_reg;
    logic [3:0]               m_entry_index_reg;
    logic [QUEUE_ID_BITS-1:0] m_target_queue_reg;
    logic [7:0]               m_expiry_byte_reg;
    logic                     m_last_reg;

    tbl_wr_t                  tbl_wr;
    tbl_rd_t                  tbl_rd;

    logic                     accept;
    logic                     out_free;
    logic                     idx_ok;
    logic                     hit;
    logic                     last_scan;
    logic                     emit;
    logic [IDX_BITS-1:0]      op_addr;

    stt_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (tbl_wr),
        .rd_addr (scan_idx_reg),
        .rd      (tbl_rd)
    );

    // Handshake and shared compare
    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign idx_ok    = ({28'd0, s_timer_index} < 32'(NUM_TIMERS));
    assign op_addr   = IDX_BITS'(s_timer_index);
    assign hit       = (tbl_rd.status == ST_RUN) && (tbl_rd.deadline <= tick_count_reg);
    assign last_scan = (scan_idx_reg == IDX_BITS'(NUM_TIMERS - 1));
    assign emit      = out_free && ((state_reg == S_ACK) || (state_reg == S_DONE) ||
                                    (state_reg == S_TICK && hit));

    // Build the table write for this cycle
    always_comb begin
        tbl_wr            = '0;
        tbl_wr.deadline   = s_deadline;
        tbl_wr.queue      = s_queue_id;
        tbl_wr.payload    = s_payload_byte;
        tbl_wr.addr       = scan_idx_reg;
        tbl_wr.status_val = ST_ALLOC;
        unique case (state_reg)
            S_IDLE: begin
                tbl_wr.addr       = op_addr;
                tbl_wr.status_we  = accept && idx_ok &&
                                    (s_operation == OP_FREE || s_operation == OP_ARM);
                tbl_wr.status_val = (s_operation == OP_FREE) ? ST_FREE : ST_RUN;
                tbl_wr.bind_we    = accept && idx_ok && (s_operation == OP_BIND);
                tbl_wr.arm_we     = accept && idx_ok && (s_operation == OP_ARM);
            end
            S_ALLOC: begin
                tbl_wr.status_we = (tbl_rd.status == ST_FREE);
            end
            S_TICK: begin
                tbl_wr.status_we = hit && out_free;
            end
            default: begin
                tbl_wr.status_we = 1'b0;
            end
        endcase
    end

    // Sequencer, tick counter and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            scan_idx_reg   <= '0;
            tick_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !emit) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        scan_idx_reg <= '0;
                        priority if (s_operation == OP_ALLOC) begin
                            state_reg <= S_ALLOC;
                        end else if (s_operation == OP_TICK) begin
                            tick_count_reg <= tick_count_reg + 32'd1;
                            state_reg      <= S_TICK;
                        end else if (s_operation == OP_FREE || s_operation == OP_BIND ||
                                     s_operation == OP_ARM) begin
                            ack_ok_reg  <= idx_ok;
                            ack_idx_reg <= s_timer_index;
                            state_reg   <= S_ACK;
                        end else begin
                            ack_ok_reg  <= 1'b0;
                            ack_idx_reg <= '0;
                            state_reg   <= S_ACK;
                        end
                    end
                end
                S_ALLOC: begin
                    // Claim the first free entry, or fail after the last one
                    if (tbl_rd.status == ST_FREE) begin
                        ack_ok_reg  <= 1'b1;
                        ack_idx_reg <= 4'(scan_idx_reg);
                        state_reg   <= S_ACK;
                    end else if (last_scan) begin
                        ack_ok_reg  <= 1'b0;
                        ack_idx_reg <= '0;
                        state_reg   <= S_ACK;
                    end else begin
                        scan_idx_reg <= scan_idx_reg + IDX_BITS'(1);
                    end
                end
                S_ACK: begin
                    if (out_free) begin
                        m_valid_reg        <= 1'b1;
                        m_kind_reg         <= KIND_ACK;
                        m_ok_reg           <= ack_ok_reg;
                        m_entry_index_reg  <= ack_idx_reg;
                        m_target_queue_reg <= '0;
                        m_expiry_byte_reg  <= '0;
                        m_last_reg         <= 1'b1;
                        state_reg          <= S_IDLE;
                    end
                end
                S_TICK: begin
                    // Emit a firing entry when the output is free; hold otherwise
                    if (!hit || out_free) begin
                        if (hit) begin
                            m_valid_reg        <= 1'b1;
                            m_kind_reg         <= KIND_EXPIRY;
                            m_ok_reg           <= 1'b1;
                            m_entry_index_reg  <= 4'(scan_idx_reg);
                            m_target_queue_reg <= tbl_rd.queue;
                            m_expiry_byte_reg  <= tbl_rd.payload;
                            m_last_reg         <= 1'b0;
                        end
                        if (last_scan) begin
                            state_reg <= S_DONE;
                        end else begin
                            scan_idx_reg <= scan_idx_reg + IDX_BITS'(1);
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        m_valid_reg        <= 1'b1;
                        m_kind_reg         <= KIND_DONE;
                        m_ok_reg           <= 1'b1;
                        m_entry_index_reg  <= '0;
                        m_target_queue_reg <= '0;
                        m_expiry_byte_reg  <= '0;
                        m_last_reg         <= 1'b1;
                        state_reg          <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_ok           = m_ok_reg;
    assign m_entry_index  = m_entry_index_reg;
    assign m_target_queue = m_target_queue_reg;
    assign m_expiry_byte  = m_expiry_byte_reg;
    assign m_last         = m_last_reg;

    // After an accepted item the sequencer is busy, so s_ready is low in the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("s_ready high right after an item was accepted");

    // A tick starts its scan at entry zero
    a_tick_scan_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_operation == OP_TICK) |=> (state_reg == S_TICK && scan_idx_reg == '0))
        else $error("tick scan did not start at entry zero");

    // A firing entry with a free output becomes an expiry result next cycle
    a_expiry_emitted: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TICK && hit && out_free) |=>
            (m_valid_reg && m_kind_reg == KIND_EXPIRY && !m_last_reg))
        else $error("firing entry did not produce an expiry result");

    // The tick count moves only on an accepted tick
    a_tick_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |=> $stable(tick_count_reg))
        else $error("tick count changed outside a tick acceptance");

endmodule
